FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the range-limited Lehmer generator.
// Included by every module that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define LRR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define LRR_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define LRR_ASSERT(lbl, clk, rstn, prop, msg)
`define LRR_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

FILE: rtl/lrr_pkg.sv
// Package for the range-limited Lehmer generator: sequencer states and
// generator constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lrr_pkg;

  localparam logic [14:0] LCG_MULT = 15'd16807;
  localparam int unsigned STATE_W = 31;
  localparam int unsigned CNT_W = 5;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(STATE_W - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RANGE,
    S_MAG,
    S_ADD1,
    S_FOLD1,
    S_ADD2,
    S_FOLD2,
    S_DIV,
    S_OUT
  } lrr_state_t;

endpackage

`default_nettype wire

FILE: rtl/lehmer_random_in_range_top.sv
// Top level of the range-limited Lehmer generator: sequencer, shared adder,
// multiplier and bit-serial remainder. Depends on lrr_pkg and assert_macros.svh.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_seed_value) loads the generator
//   state with the seed masked to 31 bits, or 1 when that is zero. It is
//   taken only while the block is idle, and has priority over a request.
//   in channel (in_valid/in_ready, in_range_low, in_range_high) carries one
//   request; each request advances the state once and yields one result.
//   out channel (out_valid/out_ready, out_random_value) returns
//   low + (state mod |high - low|), or low when the range is zero.
//   Sequence: after the input transaction, the sequencer forms the range and
//   the partial products of the low 16 and high 15 state bits, then two adds
//   and two folds, then the restoring remainder (one bit per cycle on the single
//   33-bit adder) and the final add. in_ready rises with out_valid; a new
//   request is taken only after the last result is registered.
//   A stalled receiver holds the result in the output register; the next
//   request is still taken and runs until its final add, which waits for
//   the output register to drain.
//   Reset: state returns to 1, the sequencer to idle, out_valid low.
`timescale 1ns / 1ps
`default_nettype none

module lehmer_random_in_range_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [31:0] cfg_seed_value,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_range_low,
  input  wire logic signed [31:0] in_range_high,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_random_value
);

  lrr_pkg::lrr_state_t state_r, state_nxt;
  logic [30:0] x_r, x_nxt;
  logic [31:0] low_r, low_nxt;
  logic [31:0] high_r, high_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic [30:0] lo_r, lo_nxt;
  logic [29:0] hi_r, hi_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [lrr_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_r, out_nxt;

  logic [31:0] alu_a;
  logic [31:0] alu_b;
  logic        alu_inv;
  logic        alu_cin;
  logic [32:0] alu_sum;
  logic [15:0] mul_opnd;
  logic [30:0] mul_prod;

  assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_inv ? ~alu_b : alu_b)} + 33'(alu_cin);
  assign mul_opnd = (state_r == lrr_pkg::S_RANGE) ? x_r[15:0] : {1'b0, x_r[30:16]};
  assign mul_prod = 31'(lrr_pkg::LCG_MULT) * 31'(mul_opnd);

  assign cfg_ready = (state_r == lrr_pkg::S_IDLE);
  assign in_ready = (state_r == lrr_pkg::S_IDLE) && !cfg_valid;
  assign out_valid = out_valid_r;
  assign out_random_value = out_r;

  always_comb begin
    state_nxt = state_r;
    x_nxt = x_r;
    low_nxt = low_r;
    high_nxt = high_r;
    mag_nxt = mag_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    alu_a = '0;
    alu_b = '0;
    alu_inv = 1'b0;
    alu_cin = 1'b0;
    unique case (state_r)
      lrr_pkg::S_IDLE: begin
        if (cfg_valid) begin
          x_nxt = (cfg_seed_value[30:0] == '0) ? 31'd1 : cfg_seed_value[30:0];
        end else if (in_valid) begin
          low_nxt = in_range_low;
          high_nxt = in_range_high;
          state_nxt = lrr_pkg::S_RANGE;
        end
      end
      lrr_pkg::S_RANGE: begin
        alu_a = high_r;
        alu_b = low_r;
        alu_inv = 1'b1;
        alu_cin = 1'b1;
        mag_nxt = alu_sum[31:0];
        lo_nxt = mul_prod;
        state_nxt = lrr_pkg::S_MAG;
      end
      lrr_pkg::S_MAG: begin
        alu_b = mag_r;
        alu_inv = 1'b1;
        alu_cin = 1'b1;
        if (mag_r[31]) begin
          mag_nxt = alu_sum[31:0];
        end
        hi_nxt = mul_prod[29:0];
        state_nxt = lrr_pkg::S_ADD1;
      end
      lrr_pkg::S_ADD1: begin
        alu_a = {1'b0, lo_r};
        alu_b = {1'b0, hi_r[14:0], 16'h0000};
        acc_nxt = alu_sum[31:0];
        state_nxt = lrr_pkg::S_FOLD1;
      end
      lrr_pkg::S_FOLD1: begin
        alu_a = {1'b0, acc_r[30:0]};
        alu_cin = acc_r[31];
        acc_nxt = alu_sum[31:0];
        state_nxt = lrr_pkg::S_ADD2;
      end
      lrr_pkg::S_ADD2: begin
        alu_a = acc_r;
        alu_b = {17'h00000, hi_r[29:15]};
        acc_nxt = alu_sum[31:0];
        state_nxt = lrr_pkg::S_FOLD2;
      end
      lrr_pkg::S_FOLD2: begin
        alu_a = {1'b0, acc_r[30:0]};
        alu_cin = acc_r[31];
        x_nxt = alu_sum[30:0];
        rem_nxt = '0;
        cnt_nxt = lrr_pkg::DIV_LAST;
        state_nxt = lrr_pkg::S_DIV;
      end
      lrr_pkg::S_DIV: begin
        alu_a = {rem_r[30:0], x_r[cnt_r]};
        alu_b = mag_r;
        alu_inv = 1'b1;
        alu_cin = 1'b1;
        rem_nxt = alu_sum[32] ? alu_sum[31:0] : alu_a;
        if (cnt_r == '0) begin
          state_nxt = lrr_pkg::S_OUT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      lrr_pkg::S_OUT: begin
        alu_a = (mag_r == '0) ? '0 : rem_r;
        alu_b = low_r;
        if (!out_valid_r || out_ready) begin
          out_nxt = alu_sum[31:0];
          out_valid_nxt = 1'b1;
          state_nxt = lrr_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lrr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrr_pkg::S_IDLE;
      x_r <= 31'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      x_r <= x_nxt;
      out_valid_r <= out_valid_nxt;
    end
    low_r <= low_nxt;
    high_r <= high_nxt;
    mag_r <= mag_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    out_r <= out_nxt;
  end

`include "assert_macros.svh"

  `LRR_NEVER(a_state_nonzero, clk, rst_n, x_r == '0, "generator state reached zero")
  `LRR_ASSERT(a_rem_below_mag, clk, rst_n, (state_r == lrr_pkg::S_DIV && mag_r != '0) |-> (rem_r < mag_r), "partial remainder not below divisor")
  `LRR_ASSERT(a_accept_starts, clk, rst_n, (in_valid && in_ready) |=> (state_r == lrr_pkg::S_RANGE), "accepted transaction did not start sequencer")
  `LRR_ASSERT(a_out_only_from_seq, clk, rst_n, $rose(out_valid_r) |-> ($past(state_r) == lrr_pkg::S_OUT), "result raised outside final step")

endmodule

`default_nettype wire
